[hw/rtl/multi_queue_urgent_front_deque_core_macros.svh]
// assertion macros used by the top level of the deque bank rtl
`ifndef MULTI_QUEUE_URGENT_FRONT_DEQUE_CORE_MACROS_SVH
`define MULTI_QUEUE_URGENT_FRONT_DEQUE_CORE_MACROS_SVH

// condition must hold at every edge out of reset
`define MQD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define MQD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mqd_pkg.sv]
// package: sizes, codes and types of the deque bank
`timescale 1ns / 1ps
`default_nettype none
package mqd_pkg;

	localparam int NUM_QUEUES  = 32;
	localparam int QUEUE_DEPTH = 8;
	localparam int TAG_BITS    = 16;

	localparam int QIDX_W    = 5;
	localparam int IN_TAG_W  = 16;
	localparam int OUT_TAG_W = 16;
	localparam int TAG_KEEP  = (TAG_BITS < IN_TAG_W) ? TAG_BITS : IN_TAG_W;
	localparam int ENTRY_W   = TAG_KEEP + 1;

	localparam int QSEL_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam logic [1:0] ST_ADDED  = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_SERVED = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_SERVE = 1'b1;

	localparam logic [1:0] K_ADD       = 2'd0;
	localparam logic [1:0] K_SERVE     = 2'd1;
	localparam logic [1:0] K_REJ_ADD   = 2'd2;
	localparam logic [1:0] K_REJ_SERVE = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [QSEL_W-1:0]   qsel;
		logic                urgent;
		logic [TAG_KEEP-1:0] tag;
	} cmd_t;

endpackage
`default_nettype wire

[hw/rtl/mqd_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/mqd_front.sv]
// front end: takes command beats, classifies them, holds them in a two-entry queue
`timescale 1ns / 1ps
`default_nettype none
module mqd_front import mqd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  in_command,
	input  wire logic [QIDX_W-1:0]     in_qidx,
	input  wire logic                  in_urgent,
	input  wire logic [IN_TAG_W-1:0]   in_tag,
	output logic                       cmd_valid,
	output cmd_t                       cmd,
	input  wire logic                  cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       q_ok;
	cmd_t       dec;

	// queue indexes past the bank answer as rejected
	always_comb begin
		q_ok = 32'(in_qidx) < NUM_QUEUES;
		dec.qsel   = QSEL_W'(in_qidx);
		dec.urgent = in_urgent;
		dec.tag    = in_tag[TAG_KEEP-1:0];
		if (in_command == CMD_ADD) begin
			dec.kind = q_ok ? K_ADD : K_REJ_ADD;
		end else begin
			dec.kind = q_ok ? K_SERVE : K_REJ_SERVE;
		end
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/mqd_back.sv]
// back end: per-queue pointer update, entry memory access and result register
`timescale 1ns / 1ps
`default_nettype none
module mqd_back import mqd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	input  wire cmd_t                  cmd,
	output logic                       cmd_pop,
	output logic                       ram_we,
	output logic                       ram_re,
	output logic [ADDR_W-1:0]          ram_addr,
	output logic [ENTRY_W-1:0]         ram_wdata,
	input  wire logic [ENTRY_W-1:0]    ram_rdata,
	output logic                       reading,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 out_status,
	output logic [OUT_TAG_W-1:0]       out_tag,
	output logic                       out_urgent
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic                 state_q;
	logic [PTR_W-1:0]     head_q [NUM_QUEUES];
	logic [CNT_W-1:0]     occ_q  [NUM_QUEUES];
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [OUT_TAG_W-1:0] out_tag_q;
	logic                 out_urgent_q;

	logic                 out_free;
	logic                 go;
	logic [PTR_W-1:0]     head_cur;
	logic [CNT_W-1:0]     occ_cur;
	logic [PTR_W-1:0]     head_dec;
	logic [PTR_W-1:0]     head_inc;
	logic [CNT_W:0]       slot_sum;
	logic [PTR_W-1:0]     tail_slot;
	logic [PTR_W-1:0]     slot;
	logic                 upd;
	logic [PTR_W-1:0]     head_nxt;
	logic [CNT_W-1:0]     occ_nxt;
	logic                 res_valid;
	logic [1:0]           res_status;
	logic [OUT_TAG_W-1:0] res_tag;
	logic                 res_urgent;
	logic                 state_nxt;

	assign out_free = !out_valid_q || out_ready;
	assign go       = (state_q == S_IDLE) && cmd_valid && out_free;
	assign cmd_pop  = go;
	assign reading  = (state_q == S_READ);

	always_comb begin
		head_cur = head_q[cmd.qsel];
		occ_cur  = occ_q[cmd.qsel];
		head_dec = (head_cur == PTR_W'(0)) ? PTR_W'(QUEUE_DEPTH - 1) : head_cur - PTR_W'(1);
		head_inc = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : head_cur + PTR_W'(1);
		slot_sum = (CNT_W + 1)'(head_cur) + (CNT_W + 1)'(occ_cur);
		if (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			tail_slot = PTR_W'(slot_sum - (CNT_W + 1)'(QUEUE_DEPTH));
		end else begin
			tail_slot = PTR_W'(slot_sum);
		end
		slot = cmd.urgent ? head_dec : tail_slot;
	end

	always_comb begin
		upd        = 1'b0;
		head_nxt   = head_cur;
		occ_nxt    = occ_cur;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = ADDR_W'(32'(cmd.qsel) * QUEUE_DEPTH + 32'(slot));
		ram_wdata  = {cmd.urgent, cmd.tag};
		res_valid  = 1'b0;
		res_status = ST_ADDED;
		res_tag    = '0;
		res_urgent = 1'b0;
		state_nxt  = state_q;
		if (state_q == S_READ) begin
			res_valid  = 1'b1;
			res_status = ST_SERVED;
			res_tag    = OUT_TAG_W'(ram_rdata[TAG_KEEP-1:0]);
			res_urgent = ram_rdata[TAG_KEEP];
			state_nxt  = S_IDLE;
		end else if (go) begin
			res_valid = 1'b1;
			unique case (cmd.kind)
				K_ADD: begin
					if (occ_cur >= CNT_W'(QUEUE_DEPTH)) begin
						res_status = ST_FULL;
					end else begin
						ram_we     = 1'b1;
						upd        = 1'b1;
						occ_nxt    = occ_cur + CNT_W'(1);
						head_nxt   = cmd.urgent ? head_dec : head_cur;
						res_status = ST_ADDED;
					end
				end
				K_SERVE: begin
					if (occ_cur == CNT_W'(0)) begin
						res_status = ST_EMPTY;
					end else begin
						// front slot read now, result after the registered read
						ram_re    = 1'b1;
						ram_addr  = ADDR_W'(32'(cmd.qsel) * QUEUE_DEPTH + 32'(head_cur));
						upd       = 1'b1;
						occ_nxt   = occ_cur - CNT_W'(1);
						head_nxt  = head_inc;
						res_valid = 1'b0;
						state_nxt = S_READ;
					end
				end
				K_REJ_ADD:   res_status = ST_FULL;
				K_REJ_SERVE: res_status = ST_EMPTY;
				default:     res_status = ST_EMPTY;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (upd) begin
				head_q[cmd.qsel] <= head_nxt;
				occ_q[cmd.qsel]  <= occ_nxt;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_status_q <= res_status;
			out_tag_q    <= res_tag;
			out_urgent_q <= res_urgent;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_tag    = out_tag_q;
	assign out_urgent = out_urgent_q;

endmodule
`default_nettype wire

[hw/rtl/multi_queue_urgent_front_deque_core.sv]
// top level of the bank of bounded double-ended queues
// A bank of NUM_QUEUES bounded deques of QUEUE_DEPTH entries each; every command beat
// gives exactly one result beat. An add puts {urgent, tag} at the front of the addressed
// queue when urgent, else at the back, and answers added, or full when the queue holds
// QUEUE_DEPTH entries or the index is past the bank. A serve pops the front entry and
// answers served with its tag and urgency, or empty. Commands pass a two-entry front
// queue, then the back end executes them: an add or any refused command is answered
// straight from the idle state, a serve passes through a read state as well, since the
// front entry comes out of a single-port entry memory with a registered read. The result
// sits in an output register, so new commands are still taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_queue_urgent_front_deque_core_macros.svh"
module multi_queue_urgent_front_deque_core import mqd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// [4:0] queue_index, [5] urgent, [21:6] entry_tag, [23:22] zero
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] command
	input  wire logic                   s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [15:0] served_tag, [16] served_urgent, [23:17] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// [1:0] status
	output logic [1:0]                  m_axis_tuser
);

	logic                 cmd_valid;
	cmd_t                 cmd;
	logic                 cmd_pop;
	logic                 ram_we;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_addr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic                 reading;
	logic [OUT_TAG_W-1:0] out_tag;
	logic                 out_urgent;

	// front end: decode and buffer command beats
	mqd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser),
		.in_qidx    (s_axis_tdata[QIDX_W-1:0]),
		.in_urgent  (s_axis_tdata[QIDX_W]),
		.in_tag     (s_axis_tdata[QIDX_W+IN_TAG_W:QIDX_W+1]),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	// back end: pointers, occupancy and result register
	mqd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.ram_we     (ram_we),
		.ram_re     (ram_re),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata),
		.reading    (reading),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_tag    (out_tag),
		.out_urgent (out_urgent)
	);

	// entry memory, one row of QUEUE_DEPTH slots per queue
	mqd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RAM_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - OUT_TAG_W - 1)'(0), out_urgent, out_tag};

	// back end never pops an empty front queue
	`MQD_ASSERT_ALWAYS(a_pop_has_cmd, !cmd_pop || cmd_valid, "pop from empty command queue")
	// while the memory read is out, the result register is free for it
	`MQD_ASSERT_ALWAYS(a_read_out_free, !reading || !m_axis_tvalid, "result register busy during read")
	// after the memory read state, the next cycle shows a served result and no read
	`MQD_ASSERT_NEXT(a_read_result, reading,
		!reading && m_axis_tvalid && (m_axis_tuser == ST_SERVED), "serve result missing")
	// only a served result carries a tag or urgency
	`MQD_ASSERT_ALWAYS(a_unserved_zero,
		!m_axis_tvalid || (m_axis_tuser == ST_SERVED) || (m_axis_tdata == '0),
		"nonzero payload on unserved result")

endmodule
`default_nettype wire

[tb/tb_multi_queue_urgent_front_deque_core.sv]
// self-checking testbench for the bank of urgent-front bounded deques
`timescale 1ns / 1ps
module tb_multi_queue_urgent_front_deque_core;
	import mqd_pkg::*;

	// run limits: cycles before the run is declared hung, and drain time at the end
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam int RAND_PHASES = 16;
	localparam int PHASE_BEATS = 50;
	// long receiver hold-offs, counted from reset release
	localparam int HOLD_AT_A   = 600;
	localparam int HOLD_AT_B   = 2000;
	localparam int HOLD_CYCLES = 250;

	// one command beat as the host sees it
	typedef struct {
		logic                op;
		logic [QIDX_W-1:0]   qidx;
		logic                urg;
		logic [IN_TAG_W-1:0] tag;
	} cmd_beat_t;

	// one result beat
	typedef struct {
		logic [1:0]           status;
		logic [OUT_TAG_W-1:0] tag;
		logic                 urg;
	} deque_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// [4:0] queue_index, [5] urgent, [21:6] entry_tag, [23:22] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// [0] command
	logic                   s_axis_tuser = CMD_ADD;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [15:0] served_tag, [16] served_urgent, [23:17] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// [1:0] status
	logic [1:0]             m_axis_tuser;

	multi_queue_urgent_front_deque_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// commands waiting to be offered, and results still owed by the block
	cmd_beat_t     cmd_backlog[$];
	deque_result_t owed_results[$];

	// shadow of the deque bank: {urgent, tag} slots, front slot and fill level per queue
	logic [TAG_KEEP:0]  shadow_slot [NUM_QUEUES][QUEUE_DEPTH];
	int unsigned        shadow_head [NUM_QUEUES];
	int unsigned        shadow_fill [NUM_QUEUES];

	int err_count;
	int cycle_count;
	int beats_taken;
	int n_added, n_full, n_served, n_empty;

	// apply one accepted command to the shadow bank and return the result it must give
	function automatic deque_result_t deque_predict(cmd_beat_t b);
		deque_result_t r;
		int unsigned   q;
		int unsigned   slot;
		r.status = ST_ADDED;
		r.tag    = '0;
		r.urg    = 1'b0;
		q        = b.qidx;
		if (q >= NUM_QUEUES) begin
			// no queue there: an add is refused, a serve finds nothing
			r.status = (b.op == CMD_SERVE) ? ST_EMPTY : ST_FULL;
		end else if (b.op == CMD_ADD) begin
			if (shadow_fill[q] >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (b.urg) begin
					// urgent entry becomes the new front, head steps back with wrap
					shadow_head[q] = (shadow_head[q] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					slot = shadow_head[q];
				end else begin
					slot = (shadow_head[q] + shadow_fill[q]) % QUEUE_DEPTH;
				end
				shadow_slot[q][slot] = {b.urg, b.tag[TAG_KEEP-1:0]};
				shadow_fill[q]++;
			end
		end else begin
			if (shadow_fill[q] == 0) begin
				r.status = ST_EMPTY;
			end else begin
				slot     = shadow_head[q];
				r.status = ST_SERVED;
				r.tag    = OUT_TAG_W'(shadow_slot[q][slot][TAG_KEEP-1:0]);
				r.urg    = shadow_slot[q][slot][TAG_KEEP];
				shadow_head[q] = (slot + 1) % QUEUE_DEPTH;
				shadow_fill[q]--;
			end
		end
		return r;
	endfunction

	function automatic void queue_cmd(logic op, int q, logic u, logic [IN_TAG_W-1:0] tag);
		cmd_beat_t b;
		b.op   = op;
		b.qidx = QIDX_W'(q);
		b.urg  = u;
		b.tag  = tag;
		cmd_backlog.insert(cmd_backlog.size(), b);
	endfunction

	// first ten failures are shown, the rest only counted
	function automatic void log_failure(string msg);
		err_count++;
		if (err_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// ---------------------------------------------------------------- driver
	// offers the backlog in bursts of random length with random gaps, holds a beat
	// until it is taken, and predicts its result at the accepting edge
	cmd_beat_t beat_now;
	logic      offer;
	int        burst_left = 1;
	int        gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				beat_now = cmd_backlog[0];
				cmd_backlog.delete(0);
				owed_results.insert(owed_results.size(), deque_predict(beat_now));
				beats_taken++;
			end
			// a beat on offer that was not taken stays exactly as it is
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					offer = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						// about a third of the bursts follow on with no gap at all
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_axis_tvalid <= offer;
				if (offer) begin
					s_axis_tdata <= {2'b00, cmd_backlog[0].tag, cmd_backlog[0].urg,
					                 cmd_backlog[0].qidx};
					s_axis_tuser <= cmd_backlog[0].op;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	// ready follows a stall mode that changes at random intervals; twice it is held
	// low for a long stretch so the front queue and output register fill up
	int        rx_cycle;
	int        rx_mode;
	int        mode_left;
	int        hold_left;
	logic [7:0] stall_pattern = 8'hFF;

	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_cycle == HOLD_AT_A || rx_cycle == HOLD_AT_B) begin
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				if (mode_left <= 0) begin
					rx_mode       = $urandom_range(0, 3);
					mode_left     = $urandom_range(20, 120);
					stall_pattern = 8'($urandom()) | 8'h01;
				end
				mode_left--;
				case (rx_mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_axis_tready <= stall_pattern[rx_cycle % 8];
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// every taken result beat is checked against the oldest owed result
	deque_result_t got, want;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.tag    = m_axis_tdata[OUT_TAG_W-1:0];
			got.urg    = m_axis_tdata[OUT_TAG_W];
			case (got.status)
				ST_ADDED:  n_added++;
				ST_FULL:   n_full++;
				ST_SERVED: n_served++;
				default:   n_empty++;
			endcase
			if (owed_results.size() == 0) begin
				log_failure($sformatf("result beat with nothing owed: status %0d tag %h urg %b",
				                      got.status, got.tag, got.urg));
			end else begin
				want = owed_results[0];
				owed_results.delete(0);
				if (got.status !== want.status)
					log_failure($sformatf("status exp %0d got %0d", want.status, got.status));
				if (got.tag !== want.tag)
					log_failure($sformatf("served_tag exp %h got %h", want.tag, got.tag));
				if (got.urg !== want.urg)
					log_failure($sformatf("served_urgent exp %b got %b", want.urg, got.urg));
				if (m_axis_tdata[OUT_TDATA_W-1:OUT_TAG_W+1] !== '0)
					log_failure($sformatf("tdata pad bits not zero: %h", m_axis_tdata));
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
			         owed_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus and end
	initial begin
		int            hot [3];
		int            q;
		int            add_pct;
		logic          op;

		for (int i = 0; i < NUM_QUEUES; i++) begin
			shadow_head[i] = 0;
			shadow_fill[i] = 0;
		end

		// directed: empty serve, fill queue 0 with mixed urgency so the head wraps,
		// refused adds when full, drain in order, then the last queue at tag extremes
		queue_cmd(CMD_SERVE, 0, 1'b0, 16'h0000);
		queue_cmd(CMD_ADD,   0, 1'b0, 16'h0000);
		queue_cmd(CMD_ADD,   0, 1'b1, 16'hFFFF);
		queue_cmd(CMD_ADD,   0, 1'b0, 16'h5555);
		queue_cmd(CMD_ADD,   0, 1'b1, 16'hAAAA);
		queue_cmd(CMD_ADD,   0, 1'b1, 16'h1234);
		queue_cmd(CMD_ADD,   0, 1'b0, 16'h8001);
		queue_cmd(CMD_ADD,   0, 1'b1, 16'h7FFE);
		queue_cmd(CMD_ADD,   0, 1'b0, 16'hC3C3);
		queue_cmd(CMD_ADD,   0, 1'b1, 16'h0F0F);
		queue_cmd(CMD_ADD,   0, 1'b0, 16'hF0F0);
		for (int i = 0; i < QUEUE_DEPTH + 1; i++)
			queue_cmd(CMD_SERVE, 0, 1'b1, 16'hFFFF);
		queue_cmd(CMD_ADD,   NUM_QUEUES - 1, 1'b1, 16'hFFFF);
		queue_cmd(CMD_SERVE, NUM_QUEUES - 1, 1'b0, 16'h0000);
		queue_cmd(CMD_SERVE, NUM_QUEUES - 1, 1'b0, 16'h0000);

		// random: phases alternate between filling and draining a few hot queues so
		// that queues regularly reach full and empty; one beat in ten goes anywhere
		for (int p = 0; p < RAND_PHASES; p++) begin
			for (int h = 0; h < 3; h++)
				hot[h] = $urandom_range(0, NUM_QUEUES - 1);
			add_pct = (p % 2 == 0) ? 80 : 30;
			for (int i = 0; i < PHASE_BEATS; i++) begin
				q  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_QUEUES - 1)
				                                 : hot[$urandom_range(0, 2)];
				op = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_SERVE;
				queue_cmd(op, q, 1'($urandom_range(0, 1)), 16'($urandom()));
			end
		end

		// single reset at the start
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || owed_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (owed_results.size() != 0)
			log_failure($sformatf("%0d results never arrived", owed_results.size()));

		$display("%0d commands through the bank: %0d added, %0d refused full", beats_taken,
		         n_added, n_full);
		$display("%0d entries served, %0d serves found an empty queue, %0d mismatches",
		         n_served, n_empty, err_count);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
